// ===== hw/rtl/bilinear_grid_sampler_unit_assert.svh =====
// Assertion macros for the grid sampler; clocked on clk, disabled in reset.
`ifndef BILINEAR_GRID_SAMPLER_UNIT_ASSERT_SVH
`define BILINEAR_GRID_SAMPLER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Condition holds in the same cycle as the trigger.
`define BGS_ASSERT_NOW(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("bgs assertion failed");

// Condition holds in the cycle after the trigger.
`define BGS_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("bgs assertion failed");

`else

`define BGS_ASSERT_NOW(label, trig, cond)
`define BGS_ASSERT_NEXT(label, trig, cond)

`endif

`endif

// ===== hw/rtl/bgs_pkg.sv =====
`default_nettype none
package bgs_pkg;

  // Store geometry
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int CHANNELS   = 4;
  localparam int XW         = $clog2(MAX_WIDTH);
  localparam int YW         = $clog2(MAX_HEIGHT);
  localparam int CHW        = 2;
  localparam int NCH_MAX    = (CHANNELS < 4) ? CHANNELS : 4;
  localparam int BANK_DEPTH = (MAX_WIDTH / 2) * (MAX_HEIGHT / 2) * CHANNELS;
  localparam int BAW        = $clog2(BANK_DEPTH);
  localparam int PIXW       = XW - 1 + YW - 1;

  // Fixed point
  localparam int ONE_Q14 = 16384;

  typedef enum logic {
    REQ_LOAD   = 1'b0,
    REQ_SAMPLE = 1'b1
  } req_type_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_CHANNELS     = 2'd2;

endpackage
`default_nettype wire

// ===== hw/rtl/bgs_if.sv =====
`default_nettype none
// Request channel
interface bgs_req_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [5:0]         pixel_x;
  logic [5:0]         pixel_y;
  logic [1:0]         channel_index;
  logic signed [15:0] pixel_value;
  logic signed [15:0] grid_x;
  logic signed [15:0] grid_y;

  modport source (output valid, req_type, pixel_x, pixel_y, channel_index,
                  pixel_value, grid_x, grid_y, input ready);
  modport sink   (input valid, req_type, pixel_x, pixel_y, channel_index,
                  pixel_value, grid_x, grid_y, output ready);
endinterface

// Result channel
interface bgs_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         out_channel;
  logic signed [15:0] sample_value;
  logic               last;

  modport source (output valid, out_channel, sample_value, last, input ready);
  modport sink   (input valid, out_channel, sample_value, last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/bilinear_grid_sampler_unit.sv =====
`default_nettype none
// Load beat: written to one of four parity banks.
// Sample beat: map and weight steps after accept, then per channel a bank read,
// multiply and sum step yielding one result; the sum step stalls while the held result is not taken.
// The four (x,y)-parity banks give all four neighbours in a single read.
// Reset (rst, synchronous) clears control and sets width 64, height 64, 4 channels;
// image memory contents stay undefined until written.
`include "bilinear_grid_sampler_unit_assert.svh"
module bilinear_grid_sampler_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [6:0] cfg_data,
  bgs_req_if.sink         in_req,
  bgs_res_if.source       out_res
);

  typedef enum logic [2:0] {
    S_IDLE, S_MAP, S_WGT, S_RD, S_MUL, S_SUM
  } state_t;

  state_t state;

  // Configuration registers
  logic [6:0] image_width;
  logic [6:0] image_height;
  logic [2:0] channels_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= 7'd64;
      image_height    <= 7'd64;
      channels_in_use <= 3'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bgs_pkg::CFG_IMAGE_WIDTH:  image_width     <= cfg_data;
        bgs_pkg::CFG_IMAGE_HEIGHT: image_height    <= cfg_data;
        bgs_pkg::CFG_CHANNELS:     channels_in_use <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Clamped dimensions and channel count
  logic [6:0] w_lim, h_lim;
  logic [2:0] n_lim;
  assign w_lim = (image_width == 7'd0) ? 7'd1 :
                 (image_width > 7'(bgs_pkg::MAX_WIDTH)) ? 7'(bgs_pkg::MAX_WIDTH) : image_width;
  assign h_lim = (image_height == 7'd0) ? 7'd1 :
                 (image_height > 7'(bgs_pkg::MAX_HEIGHT)) ? 7'(bgs_pkg::MAX_HEIGHT) :
                 image_height;
  assign n_lim = (channels_in_use == 3'd0) ? 3'd1 :
                 (channels_in_use > 3'(bgs_pkg::NCH_MAX)) ? 3'(bgs_pkg::NCH_MAX) :
                 channels_in_use;

  logic in_fire, out_fire, smp_fire;
  assign in_req.ready = (state == S_IDLE);
  assign in_fire      = in_req.valid && in_req.ready;
  assign out_fire     = out_res.valid && out_res.ready;
  assign smp_fire     = in_fire && (in_req.req_type == bgs_pkg::REQ_SAMPLE);

  // Load write port
  logic                    ld_en;
  logic [1:0]              ld_bank;
  logic [bgs_pkg::BAW-1:0] ld_addr;
  assign ld_en = in_fire && (in_req.req_type == bgs_pkg::REQ_LOAD) &&
                 ({1'b0, in_req.pixel_x} < 7'(bgs_pkg::MAX_WIDTH)) &&
                 ({1'b0, in_req.pixel_y} < 7'(bgs_pkg::MAX_HEIGHT)) &&
                 ({1'b0, in_req.channel_index} < 3'(bgs_pkg::CHANNELS));
  assign ld_bank = {in_req.pixel_y[0], in_req.pixel_x[0]};
  assign ld_addr = {in_req.pixel_y[bgs_pkg::YW-1:1], in_req.pixel_x[bgs_pkg::XW-1:1],
                    in_req.channel_index};

  // Captured sample coordinates
  logic signed [15:0] gx, gy;
  always_ff @(posedge clk) begin
    if (in_fire) begin
      gx <= in_req.grid_x;
      gy <= in_req.grid_y;
    end
  end

  // Grid to image position: floor((g + 1) * (size - 1) / 2) in Q14
  logic signed [23:0] px_prod, py_prod, px_pos, py_pos;
  assign px_prod = (24'(gx) + 24'sd16384) * $signed({17'd0, w_lim - 7'd1});
  assign py_prod = (24'(gy) + 24'sd16384) * $signed({17'd0, h_lim - 7'd1});
  assign px_pos  = px_prod >>> 1;
  assign py_pos  = py_prod >>> 1;

  logic signed [8:0] cx0, cy0;
  logic [13:0]       fx, fy;
  always_ff @(posedge clk) begin
    if (state == S_MAP) begin
      cx0 <= px_pos[22:14];
      cy0 <= py_pos[22:14];
      fx  <= px_pos[13:0];
      fy  <= py_pos[13:0];
    end
  end

  // Per-bank neighbour selection and weights
  logic [bgs_pkg::PIXW-1:0] bk_base [4];
  logic                     bk_en   [4];
  logic [28:0]              bk_wt   [4];
  logic signed [8:0]        xs [2];
  logic signed [8:0]        ys [2];
  logic [14:0]              wx [2];
  logic [14:0]              wy [2];
  logic                     xin [2];
  logic                     yin [2];

  always_comb begin
    for (int b = 0; b < 2; b++) begin
      xs[b]  = (cx0[0] == b[0]) ? cx0 : cx0 + 9'sd1;
      ys[b]  = (cy0[0] == b[0]) ? cy0 : cy0 + 9'sd1;
      wx[b]  = (cx0[0] == b[0]) ? 15'(15'd16384 - {1'b0, fx}) : {1'b0, fx};
      wy[b]  = (cy0[0] == b[0]) ? 15'(15'd16384 - {1'b0, fy}) : {1'b0, fy};
      xin[b] = !xs[b][8] && (xs[b][7:0] < {1'b0, w_lim});
      yin[b] = !ys[b][8] && (ys[b][7:0] < {1'b0, h_lim});
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_WGT) begin
      for (int bb = 0; bb < 4; bb++) begin
        bk_base[bb] <= {ys[bb / 2][bgs_pkg::YW-1:1], xs[bb % 2][bgs_pkg::XW-1:1]};
        bk_en[bb]   <= xin[bb % 2] && yin[bb / 2];
        bk_wt[bb]   <= 29'(wx[bb % 2] * wy[bb / 2]);
      end
    end
  end

  // Four parity banks, registered read
  logic [bgs_pkg::CHW-1:0] ch_cnt;
  logic signed [15:0]      rdata [4];

  for (genvar g = 0; g < 4; g++) begin : g_bank
    logic [15:0] mem [bgs_pkg::BANK_DEPTH];
    always_ff @(posedge clk) begin
      if (ld_en && (ld_bank == 2'(g))) begin
        mem[ld_addr] <= in_req.pixel_value;
      end
      rdata[g] <= mem[{bk_base[g], ch_cnt}];
    end
  end

  // Weighted neighbour products
  logic signed [45:0] prod [4];
  always_ff @(posedge clk) begin
    if (state == S_MUL) begin
      for (int bb = 0; bb < 4; bb++) begin
        prod[bb] <= bk_en[bb] ? $signed({1'b0, bk_wt[bb]}) * rdata[bb] : 46'sd0;
      end
    end
  end

  // Sum, round half up, saturate
  logic signed [47:0] acc;
  logic signed [19:0] rnd;
  logic signed [15:0] sat;
  assign acc = 48'(prod[0]) + 48'(prod[1]) + 48'(prod[2]) + 48'(prod[3])
             + 48'sd134217728;
  assign rnd = acc[47:28];
  assign sat = (rnd > 20'sd32767)  ? 16'sd32767 :
               (rnd < -20'sd32768) ? -16'sd32768 : rnd[15:0];

  logic [1:0] ch_top;
  logic       ch_last;
  logic       res_load;
  assign ch_top   = 2'(n_lim - 3'd1);
  assign ch_last  = (ch_cnt == ch_top);
  assign res_load = (state == S_SUM) && (!out_res.valid || out_res.ready);

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      ch_cnt        <= '0;
      out_res.valid <= 1'b0;
    end else begin
      // a new result replaces the one leaving in the same cycle
      if (out_fire && !res_load) begin
        out_res.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (smp_fire) begin
            state <= S_MAP;
          end
        end
        S_MAP: state <= S_WGT;
        S_WGT: begin
          ch_cnt <= '0;
          state  <= S_RD;
        end
        S_RD:  state <= S_MUL;
        S_MUL: state <= S_SUM;
        S_SUM: begin
          if (res_load) begin
            out_res.valid        <= 1'b1;
            out_res.out_channel  <= ch_cnt;
            out_res.sample_value <= sat;
            out_res.last         <= ch_last;
            if (ch_last) begin
              state <= S_IDLE;
            end else begin
              ch_cnt <= ch_cnt + 1'b1;
              state  <= S_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  `BGS_ASSERT_NEXT(a_sample_starts, smp_fire, state == S_MAP)
  `BGS_ASSERT_NOW(a_last_channel, out_res.valid && out_res.last, out_res.out_channel == ch_top)
  `BGS_ASSERT_NEXT(a_done_idle, res_load && ch_last, state == S_IDLE && out_res.valid)

endmodule
`default_nettype wire
